// ===== rtl/sostg_pkg.sv =====
// Package for the sum-of-sines texture generator.
// Holds sizes, opcodes, sine polynomial constants and the exponential table.
// Depends on nothing.
`default_nettype none
package sostg_pkg;

  localparam int HARMONICS      = 10;
  localparam int CHANNELS       = 3;
  localparam int COORD_BITS     = 10;
  localparam int SINE_ADDR_BITS = 12;
  localparam int EXP_TABLE_SIZE = 257;

  localparam int SLOTS      = CHANNELS * HARMONICS;
  localparam int OUT_FIELDS = 3;
  localparam int ACC_W      = 40;

  // Operation codes carried in tuser.
  localparam logic OP_GEN   = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Odd polynomial coefficients of sin(pi/2*u), Q30.
  localparam logic [31:0] SC1  = 32'd1686629713;
  localparam logic [31:0] SC3  = 32'd693598668;
  localparam logic [31:0] SC5  = 32'd85569306;
  localparam logic [31:0] SC7  = 32'd5026995;
  localparam logic [31:0] SC9  = 32'd172272;
  localparam logic [31:0] SC11 = 32'd3864;

  typedef logic [7:0] exp_lut_t [EXP_TABLE_SIZE];

  // Builds floor(255*exp(i/64-4)) by repeated multiplication with exp(-1/64) in Q64.
  function automatic exp_lut_t build_exp_lut();
    logic [63:0]  r;
    logic [63:0]  t;
    logic [63:0]  v;
    logic [127:0] pr;
    exp_lut_t     lut;
    t = 64'd1 << 58;
    r = 64'd0;
    r = r - t;
    t = t / 128;  r = r + t;
    t = t / 192;  r = r - t;
    t = t / 256;  r = r + t;
    t = t / 320;  r = r - t;
    t = t / 384;  r = r + t;
    t = t / 448;  r = r - t;
    t = t / 512;  r = r + t;
    t = t / 576;  r = r - t;
    t = t / 640;  r = r + t;
    t = t / 704;  r = r - t;
    t = t / 768;  r = r + t;
    v = 64'd255 << 56;
    lut[EXP_TABLE_SIZE-1] = 8'd255;
    for (int i = EXP_TABLE_SIZE - 2; i >= 0; i--) begin
      pr = {64'd0, v} * {64'd0, r};
      v = pr[127:64];
      lut[i] = v[63:56];
    end
    return lut;
  endfunction

  localparam exp_lut_t EXP_LUT = build_exp_lut();

endpackage
`default_nettype wire

// ===== rtl/sum_of_sines_texture_generator_top.sv =====
// Top level of the sum-of-sines texture generator.
// Uses sostg_pkg for sizes, sine constants and the exponential table.
`default_nettype none
// Each generate transfer (tuser = 0) gives one result transfer carrying three 8-bit
// channels; a write transfer (tuser = 1) stores one coefficient slot and gives no
// result. The pipeline has 13 register stages. One item is taken every cycle while
// the output side takes results. The whole pipeline stalls as one while a result
// waits at the output.
// Coefficients are latched per pixel at its transfer, so a write affects only pixels
// accepted after it. The coefficient table resets to zero.
module sum_of_sines_texture_generator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // pixel_x[9:0], pixel_y[19:10], coeff_slot[24:20], amplitude[40:25],
  // freq_x[64:41], freq_y[88:65], zero fill above
  input  wire logic [95:0] in_tdata,
  // opcode[0]
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // channel_0[7:0], channel_1[15:8], channel_2[23:16]
  output logic [23:0]      out_tdata
);
  import sostg_pkg::*;

  localparam int NST   = 13;
  localparam int QB    = SINE_ADDR_BITS - 2;
  localparam int XW    = QB + 1 + 32 - SINE_ADDR_BITS;
  localparam int HALF  = (HARMONICS + 1) / 2;
  localparam logic [9:0] COORD_MASK = 10'((64'd1 << COORD_BITS) - 1);
  localparam logic [QB:0] SPAN = (QB+1)'(1) << QB;
  localparam logic [31:0] PCOEF [5] = '{SC9, SC7, SC5, SC3, SC1};

  logic advance;
  logic vld_r [NST];

  logic [63:0] coef_r [SLOTS];

  // Per-lane pipeline registers.
  logic [23:0]               phase_r [SLOTS];
  logic [15:0]               amp_r   [9][SLOTS];
  logic [1:0]                quad_r  [7][SLOTS];
  logic [XW-1:0]             x_r     [6][SLOTS];
  logic [31:0]               xsq_r   [5][SLOTS];
  logic [31:0]               p_r     [5][SLOTS];
  logic [31:0]               s_r     [SLOTS];
  logic signed [16:0]        sine_r  [SLOTS];
  logic signed [ACC_W-1:0]   term_r  [SLOTS];
  logic signed [ACC_W-1:0]   half_r  [OUT_FIELDS][2];
  logic [8:0]                idx_r   [OUT_FIELDS];
  logic [23:0]               out_r;

  logic [9:0]  px;
  logic [9:0]  py;
  logic [4:0]  slot;

  assign advance    = !vld_r[NST-1] || out_tready;
  assign in_tready  = advance;
  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = out_r;
  assign px   = in_tdata[9:0] & COORD_MASK;
  assign py   = in_tdata[19:10] & COORD_MASK;
  assign slot = in_tdata[24:20];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) vld_r[k] <= 1'b0;
    end else if (advance) begin
      vld_r[0] <= in_tvalid && (in_tuser == OP_GEN);
      for (int k = 1; k < NST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Coefficient table, written by write transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < SLOTS; l++) coef_r[l] <= 64'd0;
    end else if (in_tvalid && advance && (in_tuser == OP_WRITE)) begin
      for (int l = 0; l < SLOTS; l++) begin
        if (slot == 5'(l)) coef_r[l] <= {in_tdata[40:25], in_tdata[64:41], in_tdata[88:65]};
      end
    end
  end

  // Lane datapath: phase, quarter fold, Horner steps, scaling, amplitude product.
  always_ff @(posedge clk) begin
    logic [SINE_ADDR_BITS-1:0] sidx;
    logic [QB:0]               n;
    logic [XW-1:0]             xv;
    logic [61:0]               sq;
    logic [63:0]               pm;
    logic [63:0]               sm;
    logic [47:0]               qm;
    logic [17:0]               q;
    logic [16:0]               qc;
    logic signed [33:0]        tm;
    if (advance) begin
      for (int l = 0; l < SLOTS; l++) begin
        // Stage 1: phase modulo one turn.
        phase_r[l] <= 24'(34'(px) * 34'(coef_r[l][47:24]) + 34'(py) * 34'(coef_r[l][23:0]));
        amp_r[0][l] <= coef_r[l][63:48];
        // Stage 2: fold into first quarter and square the angle.
        sidx = phase_r[l][23 -: SINE_ADDR_BITS];
        n = sidx[SINE_ADDR_BITS-2] ? SPAN - {1'b0, sidx[QB-1:0]} : {1'b0, sidx[QB-1:0]};
        xv = {n, {(32-SINE_ADDR_BITS){1'b0}}};
        sq = 62'(xv) * 62'(xv);
        x_r[0][l]    <= xv;
        xsq_r[0][l]  <= sq[61:30];
        quad_r[0][l] <= sidx[SINE_ADDR_BITS-1 -: 2];
        // Stages 3 to 7: one Horner step each.
        pm = 64'(SC11) * 64'(xsq_r[0][l]);
        p_r[0][l] <= PCOEF[0] - 32'(pm >> 30);
        for (int k = 1; k < 5; k++) begin
          pm = 64'(p_r[k-1][l]) * 64'(xsq_r[k][l]);
          p_r[k][l] <= PCOEF[k] - 32'(pm >> 30);
        end
        for (int k = 1; k < 5; k++) xsq_r[k][l] <= xsq_r[k-1][l];
        for (int k = 1; k < 6; k++) x_r[k][l] <= x_r[k-1][l];
        for (int k = 1; k < 7; k++) quad_r[k][l] <= quad_r[k-1][l];
        for (int k = 1; k < 9; k++) amp_r[k][l] <= amp_r[k-1][l];
        // Stage 8: final multiply by the angle.
        sm = 64'(p_r[4][l]) * 64'(x_r[5][l]);
        s_r[l] <= 32'(sm >> 30);
        // Stage 9: scale to Q1.15 with rounding, cap and sign.
        qm = 48'(s_r[l]) * 48'd32767 + (48'd1 << 29);
        q  = 18'(qm >> 30);
        qc = (q > 18'd32767) ? 17'd32767 : q[16:0];
        sine_r[l] <= quad_r[6][l][1] ? -$signed(qc) : $signed(qc);
        // Stage 10: amplitude times sine.
        tm = $signed({18'd0, amp_r[8][l]}) * 34'(sine_r[l]);
        term_r[l] <= ACC_W'(tm);
      end
    end
  end

  // Stages 11 to 13: per-channel sum, clamp, exponential table.
  always_ff @(posedge clk) begin
    logic signed [ACC_W-1:0] lo;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] acc;
    if (advance) begin
      for (int c = 0; c < OUT_FIELDS; c++) begin
        lo = '0;
        hi = '0;
        if (c < CHANNELS) begin
          for (int h = 0; h < HARMONICS; h++) begin
            if (h < HALF) lo = lo + term_r[c*HARMONICS + h];
            else          hi = hi + term_r[c*HARMONICS + h];
          end
        end
        half_r[c][0] <= lo;
        half_r[c][1] <= hi;
        acc = half_r[c][0] + half_r[c][1] + (ACC_W'(128) <<< 23);
        if (acc < 0)                           idx_r[c] <= 9'd0;
        else if ((acc >>> 23) > ACC_W'(256))   idx_r[c] <= 9'd256;
        else                                   idx_r[c] <= 9'(acc >>> 23);
        out_r[c*8 +: 8] <= (c < CHANNELS) ? EXP_LUT[idx_r[c]] : 8'd0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_sum_of_sines_texture_generator_top.sv =====
// Testbench for the sum-of-sines texture generator top level.
// Drives coefficient writes and pixel requests, predicts each pixel in a local model
// and checks every result transfer. Depends on sostg_pkg and the top-level RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_sum_of_sines_texture_generator_top;
  import sostg_pkg::*;

  typedef struct packed {
    logic        op;
    logic [9:0]  px;
    logic [9:0]  py;
    logic [4:0]  slot;
    logic [15:0] amp;
    logic [23:0] fx;
    logic [23:0] fy;
  } pix_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  sum_of_sines_texture_generator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pix_item_t   pending_items[$];
  logic [23:0] expected_pixels[$];
  logic [63:0] coeff_model[SLOTS];
  logic [7:0]  exp_model[EXP_TABLE_SIZE];
  int          mismatches = 0;
  int          in_gap = 0;
  int          out_gap = 0;

  // Local build of the exponential table: exp(-1/64) in Q64 from its series.
  function automatic void make_exp_model();
    logic [63:0]  r;
    logic [63:0]  t;
    logic [63:0]  v;
    logic [127:0] pr;
    r = 64'd0;
    t = 64'd1 << 58;
    for (int k = 1; k <= 12; k++) begin
      if (k > 1) t = t / (64 * k);
      if (k % 2 == 1) r = r - t;
      else r = r + t;
    end
    v = 64'd255 << 56;
    exp_model[EXP_TABLE_SIZE-1] = 8'd255;
    for (int i = EXP_TABLE_SIZE - 2; i >= 0; i--) begin
      pr = {64'd0, v} * {64'd0, r};
      v = pr[127:64];
      exp_model[i] = v[63:56];
    end
  endfunction

  // Quarter-wave sine in Q1.15 from the odd polynomial.
  function automatic longint sine_of(logic [11:0] idx);
    logic [1:0]  quad;
    logic [10:0] n;
    logic [63:0] x, x2, p, s, q;
    quad = idx[11:10];
    n = quad[0] ? (11'd1024 - {1'b0, idx[9:0]}) : {1'b0, idx[9:0]};
    x = 64'(n) << 20;
    x2 = (x * x) >> 30;
    p = 64'(SC11);
    p = 64'(SC9) - ((p * x2) >> 30);
    p = 64'(SC7) - ((p * x2) >> 30);
    p = 64'(SC5) - ((p * x2) >> 30);
    p = 64'(SC3) - ((p * x2) >> 30);
    p = 64'(SC1) - ((p * x2) >> 30);
    s = (p * x) >> 30;
    q = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (q > 64'd32767) q = 64'd32767;
    return quad[1] ? -longint'(q) : longint'(q);
  endfunction

  // Three channels of one pixel from the current coefficients.
  function automatic logic [23:0] pixel_of(logic [9:0] px, logic [9:0] py);
    logic [23:0] res;
    logic [63:0] e;
    logic [23:0] ph;
    longint      acc;
    longint      idx;
    res = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      acc = longint'(128) << 23;
      for (int h = 0; h < HARMONICS; h++) begin
        e = coeff_model[c*HARMONICS+h];
        ph = 24'(64'(px) * 64'(e[47:24]) + 64'(py) * 64'(e[23:0]));
        acc += longint'(e[63:48]) * sine_of(ph[23:12]);
      end
      if (acc < 0) idx = 0;
      else begin
        idx = acc >>> 23;
        if (idx > EXP_TABLE_SIZE - 1) idx = EXP_TABLE_SIZE - 1;
      end
      res[c*8 +: 8] = exp_model[idx];
    end
    return res;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic pix_item_t gen_item(logic [9:0] px, logic [9:0] py);
    pix_item_t it;
    it = '0;
    it.op = OP_GEN;
    it.px = px;
    it.py = py;
    it.slot = 5'($urandom);
    it.amp = 16'($urandom);
    return it;
  endfunction

  function automatic pix_item_t wr_item(logic [4:0] slot, logic [15:0] amp,
                                        logic [23:0] fx, logic [23:0] fy);
    pix_item_t it;
    it.op = OP_WRITE;
    it.px = 10'($urandom);
    it.py = 10'($urandom);
    it.slot = slot;
    it.amp = amp;
    it.fx = fx;
    it.fy = fy;
    return it;
  endfunction

  // Driver: presents queued items with random gaps, predicts at each transfer.
  always @(posedge clk) begin
    pix_item_t it;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        it = pending_items.pop_front();
        if (it.op == OP_WRITE) begin
          if (it.slot < SLOTS) coeff_model[it.slot] = {it.amp, it.fx, it.fy};
        end else begin
          expected_pixels.push_back(pixel_of(it.px, it.py));
        end
        in_gap = pick_gap();
      end
      if (in_tvalid && !in_tready) begin
        // Hold the current item.
      end else if (in_gap > 0 || pending_items.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_tvalid <= 1'b0;
      end else begin
        it = pending_items[0];
        in_tvalid <= 1'b1;
        in_tuser <= it.op;
        in_tdata <= {7'd0, it.fy, it.fx, it.amp, it.slot, it.py, it.px};
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    logic [23:0] exp_px;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          exp_px = expected_pixels.pop_front();
          if (exp_px !== out_tdata) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: ch0 exp %h got %h, ch1 exp %h got %h, ch2 exp %h got %h",
                       exp_px[7:0], out_tdata[7:0], exp_px[15:8], out_tdata[15:8],
                       exp_px[23:16], out_tdata[23:16]);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // Stimulus.
  initial begin
    int k;
    for (int i = 0; i < SLOTS; i++) coeff_model[i] = '0;
    make_exp_model();
    // Zero table, corner coordinates.
    pending_items.push_back(gen_item(10'd0, 10'd0));
    pending_items.push_back(gen_item(10'h3ff, 10'h3ff));
    // Large amplitude drives the sum close to both ends of the table range.
    pending_items.push_back(wr_item(5'd0, 16'd32768, 24'h400000, 24'd0));
    pending_items.push_back(gen_item(10'd1, 10'd0));
    pending_items.push_back(gen_item(10'd3, 10'd0));
    pending_items.push_back(gen_item(10'd2, 10'd0));
    pending_items.push_back(wr_item(5'd10, 16'hffff, 24'hffffff, 24'hffffff));
    pending_items.push_back(wr_item(5'd29, 16'd256, 24'd0, 24'h123456));
    pending_items.push_back(gen_item(10'h3ff, 10'h3ff));
    pending_items.push_back(gen_item(10'h155, 10'h2aa));
    // Slots out of range are ignored.
    pending_items.push_back(wr_item(5'd30, 16'hffff, 24'hffffff, 24'h0));
    pending_items.push_back(wr_item(5'd31, 16'hffff, 24'h0, 24'hffffff));
    pending_items.push_back(gen_item(10'd7, 10'd9));
    pending_items.push_back(wr_item(5'd0, 16'd0, 24'd0, 24'd0));
    pending_items.push_back(gen_item(10'h200, 10'h100));
    // Random part: mostly pixels, with coefficient writes mixed in.
    for (int i = 0; i < 1000; i++) begin
      k = $urandom_range(0, 9);
      if (k < 3)
        pending_items.push_back(wr_item(5'($urandom_range(0, 31)),
                                (($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 8192))),
                                24'($urandom), 24'($urandom)));
      else
        pending_items.push_back(gen_item(10'($urandom), 10'($urandom)));
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk);
    wait (expected_pixels.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
